/* sv/obb_pkg.sv */
package obb_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int QUEUE_DEPTH = 4;

endpackage

/* sv/obb_front.sv */
module obb_front #(
   parameter int CW = obb_pkg::COORD_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [3*CW-1:0]   ca,
   input  logic [3*CW-1:0]   ua0,
   input  logic [3*CW-1:0]   ua1,
   input  logic [3*CW-1:0]   ua2,
   input  logic [3*CW-1:0]   ea,
   input  logic [3*CW-1:0]   cb,
   input  logic [3*CW-1:0]   ub0,
   input  logic [3*CW-1:0]   ub1,
   input  logic [3*CW-1:0]   ub2,
   input  logic [3*CW-1:0]   eb,
   output logic              out_valid,
   input  logic              out_ready,
   output logic signed [2*CW+3:0] t_o   [3],
   output logic signed [2*CW+1:0] r_o   [3][3],
   output logic [CW-1:0]          ea_o  [3],
   output logic [CW-1:0]          eb_o  [3]
);

   // stage 1: centre difference, stage 2: per-component products, final stage: dot sums
   localparam int TW = 2*CW+4;
   localparam int RW = 2*CW+2;

   logic [2:0] v_ff, v_in;
   logic       adv1, adv2;

   logic signed [CW:0]     d_ff [3];
   logic signed [CW-1:0]   ua_ff [3][3];
   logic signed [CW-1:0]   ub_ff [3][3];
   logic [CW-1:0]          ea1_ff [3], eb1_ff [3];

   logic signed [2*CW:0]   pt_ff [3][3];
   logic signed [2*CW-1:0] pr_ff [3][3][3];
   logic [CW-1:0]          ea2_ff [3], eb2_ff [3];

   logic [3*CW-1:0] uaw [3], ubw [3];

   assign uaw[0] = ua0; assign uaw[1] = ua1; assign uaw[2] = ua2;
   assign ubw[0] = ub0; assign ubw[1] = ub1; assign ubw[2] = ub2;

   assign out_valid = v_ff[2];
   assign adv2      = !v_ff[2] || out_ready;
   assign adv1      = !v_ff[1] || adv2;
   assign in_ready  = !v_ff[0] || adv1;

   always_comb begin
      v_in = v_ff;
      if (adv2) v_in[2] = v_ff[1];
      if (adv1) v_in[1] = v_ff[0];
      if (in_ready) v_in[0] = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         for (int k = 0; k < 3; k++) begin
            d_ff[k]   <= {cb[k*CW+CW-1], cb[k*CW +: CW]}
                       - {ca[k*CW+CW-1], ca[k*CW +: CW]};
            ea1_ff[k] <= ea[k*CW +: CW];
            eb1_ff[k] <= eb[k*CW +: CW];
            for (int i = 0; i < 3; i++) begin
               ua_ff[i][k] <= uaw[i][k*CW +: CW];
               ub_ff[i][k] <= ubw[i][k*CW +: CW];
            end
         end
      end
      if (adv1) begin
         for (int i = 0; i < 3; i++) begin
            ea2_ff[i] <= ea1_ff[i];
            eb2_ff[i] <= eb1_ff[i];
            for (int k = 0; k < 3; k++) begin
               pt_ff[i][k] <= d_ff[k] * ua_ff[i][k];
               for (int j = 0; j < 3; j++)
                  pr_ff[i][j][k] <= ua_ff[i][k] * ub_ff[j][k];
            end
         end
      end
      if (adv2) begin
         for (int i = 0; i < 3; i++) begin
            ea_o[i] <= ea2_ff[i];
            eb_o[i] <= eb2_ff[i];
            t_o[i]  <= TW'(pt_ff[i][0]) + TW'(pt_ff[i][1]) + TW'(pt_ff[i][2]);
            for (int j = 0; j < 3; j++)
               r_o[i][j] <= RW'(pr_ff[i][j][0]) + RW'(pr_ff[i][j][1])
                          + RW'(pr_ff[i][j][2]);
         end
      end
   end

endmodule

/* sv/obb_queue.sv */
module obb_queue #(
   parameter int W     = 8,
   parameter int DEPTH = obb_pkg::QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_valid,
   output logic         wr_ready,
   input  logic [W-1:0] wr_data,
   output logic         rd_valid,
   input  logic         rd_ready,
   output logic [W-1:0] rd_data
);

   localparam int AW = $clog2(DEPTH);

   logic [W-1:0]  mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          wr, rd;

   assign wr_ready = cnt_ff != (AW+1)'(DEPTH);
   assign rd_valid = cnt_ff != '0;
   assign rd_data  = mem_ff[rp_ff];
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;

   always_comb begin
      wp_in  = wr ? ((wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1) : wp_ff;
      rp_in  = rd ? ((rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + (AW+1)'(wr) - (AW+1)'(rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= wr_data;
   end

endmodule

/* sv/obb_back.sv */
module obb_back #(
   parameter int CW = obb_pkg::COORD_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic signed [2*CW+3:0] t_i  [3],
   input  logic signed [2*CW+1:0] r_i  [3][3],
   input  logic [CW-1:0]          ea_i [3],
   input  logic [CW-1:0]          eb_i [3],
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic                   overlap
);

   localparam int F  = CW - 2;
   localparam int TW = 2*CW+4;
   localparam int RW = 2*CW+2;
   localparam int AW = 2*CW+2;          // |R|+1, unsigned
   localparam int PW = TW + RW;         // t*R product
   localparam int SW = PW + 4;          // sums, signed
   localparam int GW = SW + F + 2;      // compare width

   logic [2:0] v_ff, v_in;
   logic       a1, a2, a3;

   // stage 1: abs terms
   logic signed [TW-1:0] t1_ff [3];
   logic signed [RW-1:0] r1_ff [3][3];
   logic [AW-1:0]        ar1_ff [3][3];
   logic [CW-1:0]        ea1_ff [3], eb1_ff [3];

   // stage 2: products
   logic signed [PW-1:0]  tr_ff [3][3][3];       // t[a]*r[i][j]
   logic [CW+AW-1:0]      pa_ff [3][3][3];       // ea[a]*ar[i][j]
   logic [CW+AW-1:0]      pb_ff [3][3][3];       // eb[a]*ar[i][j]
   logic [CW-1:0]         ea2_ff [3], eb2_ff [3];
   logic [TW-1:0]         at2_ff [3];

   // stage 3: compares reduced
   logic                  sep_ff;

   logic [AW:0] mr [3][3];

   assign out_valid = v_ff[2];
   assign a3 = !v_ff[2] || out_ready;
   assign a2 = !v_ff[1] || a3;
   assign a1 = !v_ff[0] || a2;
   assign in_ready = a1;
   assign overlap = !sep_ff;

   always_comb begin
      v_in = v_ff;
      if (a3) v_in[2] = v_ff[1];
      if (a2) v_in[1] = v_ff[0];
      if (a1) v_in[0] = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            mr[i][j] = r_i[i][j][RW-1] ? (AW+1)'(-r_i[i][j]) + 1'b1
                                        : (AW+1)'(r_i[i][j]) + 1'b1;
   end

   // stage 3 combinational tests
   logic signed [SW-1:0] lb, le;
   logic [SW-1:0]        rb, re, mb, me;
   logic [GW-1:0]        lhs_g, rhs_g;
   logic                 sep_c;

   always_comb begin
      sep_c = 1'b0;
      lb = '0; le = '0; rb = '0; re = '0; mb = '0; me = '0;
      lhs_g = '0; rhs_g = '0;
      for (int j = 0; j < 3; j++) begin
         lb = SW'(tr_ff[0][0][j]) + SW'(tr_ff[1][1][j]) + SW'(tr_ff[2][2][j]);
         rb = (SW'(eb2_ff[j]) << (2*F)) + SW'(pa_ff[0][0][j]) + SW'(pa_ff[1][1][j])
            + SW'(pa_ff[2][2][j]);
         mb = lb[SW-1] ? SW'(-lb) : SW'(lb);
         lhs_g = GW'(mb);
         rhs_g = GW'(rb) << F;
         if (lhs_g > rhs_g) sep_c = 1'b1;
      end
      // edge axes Ai x Bj
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            le = SW'(tr_ff[(i+2)%3][(i+1)%3][j]) - SW'(tr_ff[(i+1)%3][(i+2)%3][j]);
            re = SW'(pa_ff[(i+1)%3][(i+2)%3][j]) + SW'(pa_ff[(i+2)%3][(i+1)%3][j])
               + SW'(pb_ff[(j+1)%3][i][(j+2)%3]) + SW'(pb_ff[(j+2)%3][i][(j+1)%3]);
            me = le[SW-1] ? SW'(-le) : SW'(le);
            lhs_g = GW'(me);
            rhs_g = GW'(re) << F;
            if (lhs_g > rhs_g) sep_c = 1'b1;
         end
      end
   end

   logic [GW-1:0] fl, fr;
   logic          sep_a_c;
   always_comb begin
      sep_a_c = 1'b0;
      fl = '0; fr = '0;
      for (int i = 0; i < 3; i++) begin
         fl = GW'(at2_ff[i]) << F;
         fr = (GW'(ea2_ff[i]) << (2*F)) + GW'(pb_ff[0][i][0]) + GW'(pb_ff[1][i][1])
            + GW'(pb_ff[2][i][2]);
         if (fl > fr) sep_a_c = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (a1) begin
         for (int i = 0; i < 3; i++) begin
            t1_ff[i]  <= t_i[i];
            ea1_ff[i] <= ea_i[i];
            eb1_ff[i] <= eb_i[i];
            for (int j = 0; j < 3; j++) begin
               r1_ff[i][j]  <= r_i[i][j];
               ar1_ff[i][j] <= AW'(mr[i][j]);
            end
         end
      end
      if (a2) begin
         for (int i = 0; i < 3; i++) begin
            ea2_ff[i] <= ea1_ff[i];
            eb2_ff[i] <= eb1_ff[i];
            at2_ff[i] <= t1_ff[i][TW-1] ? TW'(-t1_ff[i]) : TW'(t1_ff[i]);
         end
         for (int a = 0; a < 3; a++) begin
            for (int i = 0; i < 3; i++) begin
               for (int j = 0; j < 3; j++) begin
                  tr_ff[a][i][j] <= t1_ff[a] * r1_ff[i][j];
                  pa_ff[a][i][j] <= ea1_ff[a] * ar1_ff[i][j];
                  pb_ff[a][i][j] <= eb1_ff[a] * ar1_ff[i][j];
               end
            end
         end
      end
      if (a3) begin
         sep_ff <= sep_c || sep_a_c;
      end
   end

endmodule

/* sv/obb_overlap_test.sv */
// Throughput: one request per cycle; full only rises when the result side backs up.
// Front does the dot products, a 4-deep queue decouples it from the test back end.
// Reset (synchronous, active high) empties all stages and the queue.
module obb_overlap_test #(
   parameter int COORD_WIDTH = obb_pkg::COORD_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  logic [3*COORD_WIDTH-1:0] req_box_a_centre,
   input  logic [3*COORD_WIDTH-1:0] req_box_a_axis_x,
   input  logic [3*COORD_WIDTH-1:0] req_box_a_axis_y,
   input  logic [3*COORD_WIDTH-1:0] req_box_a_axis_z,
   input  logic [3*COORD_WIDTH-1:0] req_box_a_extents,
   input  logic [3*COORD_WIDTH-1:0] req_box_b_centre,
   input  logic [3*COORD_WIDTH-1:0] req_box_b_axis_x,
   input  logic [3*COORD_WIDTH-1:0] req_box_b_axis_y,
   input  logic [3*COORD_WIDTH-1:0] req_box_b_axis_z,
   input  logic [3*COORD_WIDTH-1:0] req_box_b_extents,
   output logic                     empty,
   input  logic                     pop,
   output logic                     rsp_overlap
);

   localparam int CW = COORD_WIDTH;
   localparam int TW = 2*CW+4;
   localparam int RW = 2*CW+2;
   localparam int QW = 3*TW + 9*RW + 6*CW;

   logic                 f_ready, f_valid, q_ready, q_valid, b_ready, b_valid;
   logic signed [TW-1:0] f_t [3];
   logic signed [RW-1:0] f_r [3][3];
   logic [CW-1:0]        f_ea [3], f_eb [3];
   logic signed [TW-1:0] q_t [3];
   logic signed [RW-1:0] q_r [3][3];
   logic [CW-1:0]        q_ea [3], q_eb [3];
   logic [QW-1:0]        q_wd, q_rd;

   assign full  = !f_ready;
   assign empty = !b_valid;

   obb_front #(.CW(CW)) u_front (
      .clock, .reset,
      .in_valid(push), .in_ready(f_ready),
      .ca(req_box_a_centre), .ua0(req_box_a_axis_x), .ua1(req_box_a_axis_y),
      .ua2(req_box_a_axis_z), .ea(req_box_a_extents),
      .cb(req_box_b_centre), .ub0(req_box_b_axis_x), .ub1(req_box_b_axis_y),
      .ub2(req_box_b_axis_z), .eb(req_box_b_extents),
      .out_valid(f_valid), .out_ready(q_ready),
      .t_o(f_t), .r_o(f_r), .ea_o(f_ea), .eb_o(f_eb)
   );

   assign q_wd = {f_t[0], f_t[1], f_t[2],
                  f_r[0][0], f_r[0][1], f_r[0][2],
                  f_r[1][0], f_r[1][1], f_r[1][2],
                  f_r[2][0], f_r[2][1], f_r[2][2],
                  f_ea[0], f_ea[1], f_ea[2], f_eb[0], f_eb[1], f_eb[2]};

   obb_queue #(.W(QW), .DEPTH(obb_pkg::QUEUE_DEPTH)) u_queue (
      .clock, .reset,
      .wr_valid(f_valid), .wr_ready(q_ready), .wr_data(q_wd),
      .rd_valid(q_valid), .rd_ready(b_ready), .rd_data(q_rd)
   );

   assign {q_t[0], q_t[1], q_t[2],
           q_r[0][0], q_r[0][1], q_r[0][2],
           q_r[1][0], q_r[1][1], q_r[1][2],
           q_r[2][0], q_r[2][1], q_r[2][2],
           q_ea[0], q_ea[1], q_ea[2], q_eb[0], q_eb[1], q_eb[2]} = q_rd;

   obb_back #(.CW(CW)) u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(b_ready),
      .t_i(q_t), .r_i(q_r), .ea_i(q_ea), .eb_i(q_eb),
      .out_valid(b_valid), .out_ready(pop),
      .overlap(rsp_overlap)
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty)
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> $stable(rsp_overlap))
      else $error("result changed while stalled");
   assert property (@(posedge clock) reset |=> empty && !full)
      else $error("reset did not clear pipeline");
`endif

endmodule

/* verif/tb_obb_overlap_test.sv */
`timescale 1ns / 1ps

module tb_obb_overlap_test;

   localparam int CW = obb_pkg::COORD_WIDTH_DEF;
   localparam int FW = 3 * CW;
   localparam int AF = CW - 2;
   localparam int WW = 160;
   localparam longint CYCLE_LIMIT = 400000;

   typedef logic [FW-1:0] field_t;
   typedef struct {
      field_t ac, ax, ay, az, ae, bc, bx, by, bz, be;
   } box_pair_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full, empty, rsp_overlap;
   field_t req_box_a_centre = '0, req_box_a_axis_x = '0, req_box_a_axis_y = '0;
   field_t req_box_a_axis_z = '0, req_box_a_extents = '0, req_box_b_centre = '0;
   field_t req_box_b_axis_x = '0, req_box_b_axis_y = '0, req_box_b_axis_z = '0;
   field_t req_box_b_extents = '0;

   logic overlap_expected[$];
   int errors = 0;
   longint cycles = 0;
   int hold_pop = 0;

   obb_overlap_test dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_box_a_centre(req_box_a_centre), .req_box_a_axis_x(req_box_a_axis_x),
      .req_box_a_axis_y(req_box_a_axis_y), .req_box_a_axis_z(req_box_a_axis_z),
      .req_box_a_extents(req_box_a_extents), .req_box_b_centre(req_box_b_centre),
      .req_box_b_axis_x(req_box_b_axis_x), .req_box_b_axis_y(req_box_b_axis_y),
      .req_box_b_axis_z(req_box_b_axis_z), .req_box_b_extents(req_box_b_extents),
      .empty(empty), .pop(pop), .rsp_overlap(rsp_overlap)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic signed [WW-1:0] comp_s(field_t f, int k);
      logic signed [CW-1:0] v;
      v = f[k*CW +: CW];
      return WW'(v);
   endfunction

   function automatic logic signed [WW-1:0] comp_u(field_t f, int k);
      return WW'(f[k*CW +: CW]);
   endfunction

   function automatic logic signed [WW-1:0] absw(logic signed [WW-1:0] v);
      return v < 0 ? -v : v;
   endfunction

   // exact 15-axis separating axis test, all terms at 160 bits
   function automatic logic boxes_overlap(box_pair_t p);
      logic signed [WW-1:0] ca[3], cb[3], ea[3], eb[3], ua[3][3], ub[3][3];
      logic signed [WW-1:0] t[3], r[3][3], ar[3][3], lhs, rhs;
      logic sep;
      int i1, i2, j1, j2;
      sep = 1'b0;
      for (int k = 0; k < 3; k++) begin
         ca[k] = comp_s(p.ac, k); cb[k] = comp_s(p.bc, k);
         ea[k] = comp_u(p.ae, k); eb[k] = comp_u(p.be, k);
         ua[0][k] = comp_s(p.ax, k); ua[1][k] = comp_s(p.ay, k);
         ua[2][k] = comp_s(p.az, k);
         ub[0][k] = comp_s(p.bx, k); ub[1][k] = comp_s(p.by, k);
         ub[2][k] = comp_s(p.bz, k);
      end
      for (int i = 0; i < 3; i++) begin
         t[i] = 0;
         for (int k = 0; k < 3; k++) t[i] += (cb[k] - ca[k]) * ua[i][k];
         for (int j = 0; j < 3; j++) begin
            r[i][j] = 0;
            for (int k = 0; k < 3; k++) r[i][j] += ua[i][k] * ub[j][k];
            ar[i][j] = absw(r[i][j]) + 1;
         end
      end
      for (int i = 0; i < 3; i++) begin
         rhs = ea[i] <<< (2 * AF);
         for (int j = 0; j < 3; j++) rhs += eb[j] * ar[i][j];
         if ((absw(t[i]) <<< AF) > rhs) sep = 1'b1;
      end
      for (int j = 0; j < 3; j++) begin
         lhs = 0;
         rhs = eb[j] <<< (2 * AF);
         for (int i = 0; i < 3; i++) begin
            lhs += t[i] * r[i][j];
            rhs += ea[i] * ar[i][j];
         end
         if (absw(lhs) > (rhs <<< AF)) sep = 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
         i1 = (i + 1) % 3; i2 = (i + 2) % 3;
         for (int j = 0; j < 3; j++) begin
            j1 = (j + 1) % 3; j2 = (j + 2) % 3;
            lhs = t[i2] * r[i1][j] - t[i1] * r[i2][j];
            rhs = ea[i1] * ar[i2][j] + ea[i2] * ar[i1][j]
                + eb[j1] * ar[i][j2] + eb[j2] * ar[i][j1];
            if (absw(lhs) > (rhs <<< AF)) sep = 1'b1;
         end
      end
      return !sep;
   endfunction

   function automatic int gap_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic field_t rand_field();
      return FW'({$urandom(), $urandom()});
   endfunction

   function automatic field_t pack3(int x, int y, int z);
      return {CW'(z), CW'(y), CW'(x)};
   endfunction

   int gaps_on = 0;

   task automatic send_request(box_pair_t p);
      int g;
      g = gaps_on ? gap_len() : 0;
      if (g > 0) begin
         push <= 1'b0;
         repeat (g) @(posedge clock);
      end
      push <= 1'b1;
      req_box_a_centre <= p.ac; req_box_a_axis_x <= p.ax; req_box_a_axis_y <= p.ay;
      req_box_a_axis_z <= p.az; req_box_a_extents <= p.ae; req_box_b_centre <= p.bc;
      req_box_b_axis_x <= p.bx; req_box_b_axis_y <= p.by; req_box_b_axis_z <= p.bz;
      req_box_b_extents <= p.be;
      @(posedge clock);
      while (full) @(posedge clock);
      overlap_expected.push_back(boxes_overlap(p));
   endtask

   int pop_gaps = 0;

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (overlap_expected.size() == 0) begin
            $error("unexpected result: overlap=%0b", rsp_overlap);
            errors++;
         end else begin
            logic e;
            e = overlap_expected.pop_front();
            if (rsp_overlap !== e) begin
               $error("overlap mismatch: expected %0b actual %0b", e, rsp_overlap);
               errors++;
            end
         end
      end
   end

   // receiver: random stalls, plus a long hold when requested
   initial begin
      int g;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_pop > 0) begin
            pop <= 1'b0;
            hold_pop--;
         end else if (pop_gaps && $urandom_range(0, 2) == 0) begin
            pop <= 1'b0;
            g = gap_len();
            repeat (g) @(posedge clock);
         end else begin
            pop <= 1'b1;
         end
      end
   end

   function automatic box_pair_t aligned_pair(int dx, int dy, int dz, int ea, int eb);
      box_pair_t p;
      int one;
      one = 1 << AF;
      p.ac = '0;
      p.bc = pack3(dx, dy, dz);
      p.ax = pack3(one, 0, 0); p.ay = pack3(0, one, 0); p.az = pack3(0, 0, one);
      p.bx = p.ax; p.by = p.ay; p.bz = p.az;
      p.ae = pack3(ea, ea, ea); p.be = pack3(eb, eb, eb);
      return p;
   endfunction

   function automatic box_pair_t random_pair();
      box_pair_t p;
      int mode;
      mode = $urandom_range(0, 3);
      if (mode == 0) begin
         p = '{rand_field(), rand_field(), rand_field(), rand_field(), rand_field(),
               rand_field(), rand_field(), rand_field(), rand_field(), rand_field()};
      end else begin
         // near-unit axes and nearby centres so both answers are common
         int h;
         h = 1 << AF;
         p = aligned_pair($urandom_range(0, 2047) - 1024, $urandom_range(0, 2047) - 1024,
                          $urandom_range(0, 2047) - 1024, $urandom_range(0, 511),
                          $urandom_range(0, 511));
         if (mode == 2) begin
            // 45-degree rotation of B about z
            p.bx = pack3(11585, 11585, 0);
            p.by = pack3(-11585, 11585, 0);
         end else if (mode == 3) begin
            p.ax = pack3(h - $urandom_range(0, 300), $urandom_range(0, 600) - 300,
                         $urandom_range(0, 600) - 300);
            p.bz = pack3($urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300,
                         -h + $urandom_range(0, 300));
            p.ae = {CW'($urandom), CW'($urandom_range(0, 600)), CW'($urandom_range(0, 600))};
         end
      end
      return p;
   endfunction

   task automatic wait_drained();
      push <= 1'b0;
      while (overlap_expected.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      box_pair_t p;
      field_t ones, maxs, mins;
      ones = '1;
      maxs = pack3(32767, 32767, 32767);
      mins = pack3(-32768, -32768, -32768);
      send_request(aligned_pair(0, 0, 0, 256, 256));
      send_request(aligned_pair(512, 0, 0, 256, 256));     // faces touch
      send_request(aligned_pair(513, 0, 0, 256, 256));     // just apart
      send_request(aligned_pair(0, 0, -600, 256, 256));
      send_request(aligned_pair(0, 0, 0, 0, 0));
      p = aligned_pair(0, 0, 0, 0, 0);
      p.ae = ones; p.be = ones;
      send_request(p);
      p = aligned_pair(0, 0, 0, 0, 0);
      p.ac = maxs; p.bc = mins;
      send_request(p);
      p.ae = ones; p.be = ones;
      send_request(p);
      p = '{ones, ones, ones, ones, ones, ones, ones, ones, ones, ones};
      send_request(p);
      p = '{mins, mins, mins, mins, ones, maxs, maxs, maxs, maxs, ones};
      send_request(p);
      p = '{maxs, maxs, maxs, maxs, '0, mins, mins, mins, mins, '0};
      send_request(p);
      p = '{default: '0};
      send_request(p);
      // non-orthogonal axes
      p = aligned_pair(300, 300, 0, 128, 128);
      p.ay = p.ax; p.by = pack3(11585, 11585, 0);
      send_request(p);
      p = aligned_pair(700, 0, 0, 256, 256);
      p.bx = pack3(11585, 11585, 0); p.by = pack3(-11585, 11585, 0);
      send_request(p);
      wait_drained();
   endtask

   task automatic test_random();
      gaps_on = 1;
      pop_gaps = 1;
      for (int n = 0; n < 380; n++) begin
         if (n == 200) gaps_on = 0;
         if (n == 260) gaps_on = 1;
         send_request(random_pair());
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      gaps_on = 0;
      hold_pop = 60;
      for (int n = 0; n < 40; n++) send_request(random_pair());
      wait_drained();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random();
      repeat (20) @(posedge clock);
      if (errors == 0 && overlap_expected.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* files.f */
sv/obb_pkg.sv
sv/obb_front.sv
sv/obb_queue.sv
sv/obb_back.sv
sv/obb_overlap_test.sv
verif/tb_obb_overlap_test.sv
